FILE: sv/rwp_pkg.sv
`timescale 1ns / 1ps
package rwp_pkg;

  // One input beat: a file byte and its end-of-file mark.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  // One result beat.
  typedef struct packed {
    logic        sample_valid;
    logic [7:0]  sample_byte;
    logic        done_res;
    logic        ok;
    logic [15:0] num_channels;
    logic [31:0] sample_rate;
    logic [31:0] avg_bytes_per_second;
    logic [15:0] block_align;
    logic [15:0] sample_bits;
    logic [31:0] data_size;
  } out_t;

  // Parser phase, one-hot.
  typedef enum logic [6:0] {
    PH_HEADER = 7'b0000001,
    PH_CHUNK  = 7'b0000010,
    PH_FMT    = 7'b0000100,
    PH_SKIP   = 7'b0001000,
    PH_PAD    = 7'b0010000,
    PH_DATA   = 7'b0100000,
    PH_IDLE   = 7'b1000000
  } phase_t;

  // Controller state, one-hot.
  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_CHECK = 2'b10
  } ctl_state_t;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [4:0]  RIFF_TAG_LEN  = 5'd4;
  localparam logic [4:0]  RIFF_HDR_LEN  = 5'd12;
  localparam logic [4:0]  CHUNK_HDR_LEN = 5'd8;
  localparam logic [4:0]  FMT_LEN       = 5'd16;
  localparam logic [32:0] POS_MAX       = 33'h1_FFFF_FFFF;
  localparam logic [5:0]  DIV_STEPS     = 6'd32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic start;
    logic load_sample;
    logic report;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sample_now;
    logic div_done;
    logic out_busy;
  } stat_t;

  // Decoded header fields and the checks that need no arithmetic unit.
  typedef struct packed {
    logic        base_ok;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [31:0] avg_rate;
    logic [15:0] align;
    logic [15:0] bits;
    logic [31:0] data_size;
  } fmt_info_t;

endpackage

FILE: sv/rwp_parse.sv
`timescale 1ns / 1ps
module rwp_parse (
  input  logic               clk,
  input  logic               rst,
  input  rwp_pkg::cmd_t      cmd,
  input  rwp_pkg::in_t       din,
  output logic               sample_now,
  output rwp_pkg::fmt_info_t info
);

  rwp_pkg::phase_t phase, phase_next;
  logic [32:0] pos, pos_next;
  logic [32:0] span_end, span_end_next;
  logic [31:0] remaining, remaining_next;
  logic [63:0] hshift, hshift_next;
  logic [4:0]  bcount, bcount_next;
  logic        pad, pad_next;
  logic        failed, failed_next;
  logic        have_fmt, have_fmt_next;
  logic        have_data, have_data_next;
  logic [15:0] tag, tag_next;
  logic [15:0] channels, channels_next;
  logic [31:0] rate, rate_next;
  logic [31:0] avg_rate, avg_rate_next;
  logic [15:0] align, align_next;
  logic [15:0] bits, bits_next;
  logic [31:0] dsize, dsize_next;

  logic        fin;
  logic [33:0] fin_pos;
  logic [33:0] pos_plus1;
  logic [33:0] endp;
  logic [31:0] ck_size;
  logic [3:0]  idx;

  assign pos_plus1 = {1'b0, pos} + 34'd1;
  assign ck_size   = hshift_next[63:32];
  assign endp      = pos_plus1 + {2'b00, ck_size};
  assign idx       = bcount[3:0];

  // Next-state logic for one accepted byte.
  always_comb begin
    phase_next     = phase;
    span_end_next  = span_end;
    remaining_next = remaining;
    bcount_next    = bcount;
    pad_next       = pad;
    failed_next    = failed;
    have_fmt_next  = have_fmt;
    have_data_next = have_data;
    tag_next       = tag;
    channels_next  = channels;
    rate_next      = rate;
    avg_rate_next  = avg_rate;
    align_next     = align;
    bits_next      = bits;
    dsize_next     = dsize;
    sample_now     = 1'b0;
    fin            = 1'b0;
    fin_pos        = pos_plus1;
    hshift_next    = {din.data_byte, hshift[63:8]};
    pos_next       = (pos == rwp_pkg::POS_MAX) ? pos : pos_plus1[32:0];

    unique case (phase)
      rwp_pkg::PH_HEADER: begin
        bcount_next = bcount + 5'd1;
        if (bcount_next == rwp_pkg::RIFF_TAG_LEN &&
            hshift_next[63:32] != rwp_pkg::TAG_RIFF) begin
          failed_next = 1'b1;
          phase_next  = rwp_pkg::PH_IDLE;
        end else if (bcount_next == rwp_pkg::RIFF_HDR_LEN) begin
          if (hshift_next[63:32] != rwp_pkg::TAG_WAVE || hshift_next[31:0] < 32'd4) begin
            failed_next = 1'b1;
            phase_next  = rwp_pkg::PH_IDLE;
          end else begin
            span_end_next = {1'b0, hshift_next[31:0]} + 33'd8;
            bcount_next   = 5'd0;
            phase_next    = (span_end_next >= 33'd20) ? rwp_pkg::PH_CHUNK
                                                      : rwp_pkg::PH_IDLE;
          end
        end
      end
      rwp_pkg::PH_CHUNK: begin
        bcount_next = bcount + 5'd1;
        if (bcount_next == rwp_pkg::CHUNK_HDR_LEN) begin
          bcount_next    = 5'd0;
          remaining_next = ck_size;
          if (endp > {1'b0, span_end}) begin
            failed_next = 1'b1;
            phase_next  = rwp_pkg::PH_IDLE;
          end else if (hshift_next[31:0] == rwp_pkg::TAG_FMT) begin
            if (have_fmt || ck_size < 32'd16) begin
              failed_next = 1'b1;
              phase_next  = rwp_pkg::PH_IDLE;
            end else begin
              have_fmt_next = 1'b1;
              pad_next      = ck_size[0] && (endp < {1'b0, span_end});
              phase_next    = rwp_pkg::PH_FMT;
            end
          end else if (hshift_next[31:0] == rwp_pkg::TAG_DATA) begin
            if (!have_fmt) begin
              failed_next = 1'b1;
              phase_next  = rwp_pkg::PH_IDLE;
            end else begin
              have_data_next = 1'b1;
              dsize_next     = ck_size;
              phase_next     = (ck_size != 32'd0) ? rwp_pkg::PH_DATA : rwp_pkg::PH_IDLE;
            end
          end else begin
            pad_next = ck_size[0] && (endp < {1'b0, span_end});
            if (ck_size != 32'd0) begin
              phase_next = rwp_pkg::PH_SKIP;
            end else begin
              fin     = 1'b1;
              fin_pos = endp;
            end
          end
        end
      end
      rwp_pkg::PH_FMT: begin
        case (idx) inside
          4'd0:                      tag_next[7:0]       = din.data_byte;
          4'd1:                      tag_next[15:8]      = din.data_byte;
          4'd2:                      channels_next[7:0]  = din.data_byte;
          4'd3:                      channels_next[15:8] = din.data_byte;
          4'd4, 4'd5, 4'd6, 4'd7:    rate_next[8*idx[1:0] +: 8]     = din.data_byte;
          4'd8, 4'd9, 4'd10, 4'd11:  avg_rate_next[8*idx[1:0] +: 8] = din.data_byte;
          4'd12:                     align_next[7:0]     = din.data_byte;
          4'd13:                     align_next[15:8]    = din.data_byte;
          4'd14:                     bits_next[7:0]      = din.data_byte;
          default:                   bits_next[15:8]     = din.data_byte;
        endcase
        bcount_next    = bcount + 5'd1;
        remaining_next = remaining - 32'd1;
        if (bcount_next >= rwp_pkg::FMT_LEN) begin
          if (remaining_next != 32'd0) begin
            phase_next = rwp_pkg::PH_SKIP;
          end else begin
            fin = 1'b1;
          end
        end
      end
      rwp_pkg::PH_SKIP: begin
        remaining_next = remaining - 32'd1;
        if (remaining_next == 32'd0) begin
          fin = 1'b1;
        end
      end
      rwp_pkg::PH_PAD: begin
        fin = 1'b1;
      end
      rwp_pkg::PH_DATA: begin
        sample_now     = 1'b1;
        remaining_next = remaining - 32'd1;
        if (remaining_next == 32'd0) begin
          phase_next = rwp_pkg::PH_IDLE;
        end
      end
      default: begin
      end
    endcase

    // End of a chunk payload: pad byte, next chunk header, or end of walk.
    if (fin) begin
      if (pad_next) begin
        pad_next   = 1'b0;
        phase_next = rwp_pkg::PH_PAD;
      end else if (fin_pos + 34'd8 <= {1'b0, span_end_next}) begin
        phase_next  = rwp_pkg::PH_CHUNK;
        bcount_next = 5'd0;
      end else begin
        phase_next = rwp_pkg::PH_IDLE;
      end
    end
  end

  // Parser state; cleared after each file's report.
  always_ff @(posedge clk) begin
    if (rst || cmd.report) begin
      phase     <= rwp_pkg::PH_HEADER;
      pos       <= '0;
      span_end  <= '0;
      remaining <= '0;
      hshift    <= '0;
      bcount    <= '0;
      pad       <= 1'b0;
      failed    <= 1'b0;
      have_fmt  <= 1'b0;
      have_data <= 1'b0;
      tag       <= '0;
      channels  <= '0;
      rate      <= '0;
      avg_rate  <= '0;
      align     <= '0;
      bits      <= '0;
      dsize     <= '0;
    end else if (cmd.take) begin
      phase     <= phase_next;
      pos       <= pos_next;
      span_end  <= span_end_next;
      remaining <= remaining_next;
      hshift    <= hshift_next;
      bcount    <= bcount_next;
      pad       <= pad_next;
      failed    <= failed_next;
      have_fmt  <= have_fmt_next;
      have_data <= have_data_next;
      tag       <= tag_next;
      channels  <= channels_next;
      rate      <= rate_next;
      avg_rate  <= avg_rate_next;
      align     <= align_next;
      bits      <= bits_next;
      dsize     <= dsize_next;
    end
  end

  // Checks that need only compares on the stored state.
  always_comb begin
    info.base_ok = !failed && phase != rwp_pkg::PH_HEADER && have_fmt && have_data &&
                   pos >= span_end && tag == 16'd1 && channels != 16'd0 &&
                   rate != 32'd0 && align != 16'd0 && bits != 16'd0;
    info.channels  = channels;
    info.rate      = rate;
    info.avg_rate  = avg_rate;
    info.align     = align;
    info.bits      = bits;
    info.data_size = dsize;
  end

endmodule

FILE: sv/rwp_verdict.sv
`timescale 1ns / 1ps
module rwp_verdict (
  input  logic               clk,
  input  logic               rst,
  input  rwp_pkg::cmd_t      cmd,
  input  logic [7:0]         data_byte,
  input  logic               sample_now,
  input  rwp_pkg::fmt_info_t info,
  output logic               div_done,
  output logic               out_busy,
  output logic               out_valid,
  input  logic               out_stall,
  output rwp_pkg::out_t      out_data
);

  logic [47:0] product;
  logic [15:0] rem;
  logic [16:0] rem_sh;
  logic [5:0]  div_cnt;
  logic        last_samp;
  logic [7:0]  last_byte_val;
  logic        good;

  assign div_done = (div_cnt == rwp_pkg::DIV_STEPS);
  assign out_busy = out_valid && out_stall;

  // Restoring remainder step over the data size, one bit per cycle.
  assign rem_sh = {rem, info.data_size[5'd31 - div_cnt[4:0]]};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= rwp_pkg::DIV_STEPS;
      rem     <= '0;
    end else if (cmd.start) begin
      div_cnt <= '0;
      rem     <= '0;
    end else if (!div_done) begin
      div_cnt <= div_cnt + 6'd1;
      rem     <= (rem_sh >= {1'b0, info.align}) ? 16'(rem_sh - {1'b0, info.align})
                                                : rem_sh[15:0];
    end
  end

  // Rate times alignment, registered ahead of the compare.
  always_ff @(posedge clk) begin
    product <= info.rate * info.align;
  end

  // Sample carried by the final byte waits for the verdict.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      last_samp     <= sample_now;
      last_byte_val <= data_byte;
    end
  end

  assign good = info.base_ok && ({16'd0, info.avg_rate} == product) && rem == 16'd0;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.report) begin
      out_valid <= 1'b1;
      out_data.sample_valid         <= last_samp;
      out_data.sample_byte          <= last_samp ? last_byte_val : 8'd0;
      out_data.done_res             <= 1'b1;
      out_data.ok                   <= good;
      out_data.num_channels         <= info.channels;
      out_data.sample_rate          <= info.rate;
      out_data.avg_bytes_per_second <= info.avg_rate;
      out_data.block_align          <= info.align;
      out_data.sample_bits          <= info.bits;
      out_data.data_size            <= info.data_size;
    end else if (cmd.load_sample) begin
      out_valid <= 1'b1;
      out_data.sample_valid         <= 1'b1;
      out_data.sample_byte          <= data_byte;
      out_data.done_res             <= 1'b0;
      out_data.ok                   <= 1'b0;
      out_data.num_channels         <= '0;
      out_data.sample_rate          <= '0;
      out_data.avg_bytes_per_second <= '0;
      out_data.block_align          <= '0;
      out_data.sample_bits          <= '0;
      out_data.data_size            <= '0;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: sv/rwp_ctrl.sv
`timescale 1ns / 1ps
module rwp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          last_byte,
  output logic          in_stall,
  input  rwp_pkg::stat_t stat,
  output rwp_pkg::cmd_t  cmd
);

  rwp_pkg::ctl_state_t state, state_next;

  // Command decode.
  always_comb begin
    in_stall        = !(state == rwp_pkg::ST_RUN && !stat.out_busy);
    cmd.take        = in_valid && !in_stall;
    cmd.start       = cmd.take && last_byte;
    cmd.load_sample = cmd.take && !last_byte && stat.sample_now;
    cmd.report      = state == rwp_pkg::ST_CHECK && stat.div_done && !stat.out_busy;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      rwp_pkg::ST_RUN:   if (cmd.start) state_next = rwp_pkg::ST_CHECK;
      rwp_pkg::ST_CHECK: if (cmd.report) state_next = rwp_pkg::ST_RUN;
      default:           state_next = rwp_pkg::ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rwp_pkg::ST_RUN;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/riff_wave_pcm_parser.sv
`timescale 1ns / 1ps
// Accepts one file byte per cycle while the output is not stalled; a data payload
// byte appears on the output in the cycle after its beat. On the last byte the
// verdict waits on the bit-serial remainder unit that checks the data size against
// the block alignment; no byte is taken until the verdict is reported.
// Reset is synchronous and active high; it returns the parser to the RIFF header.
module riff_wave_pcm_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  rwp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rwp_pkg::out_t out_data
);

  rwp_pkg::cmd_t      cmd;
  rwp_pkg::stat_t     stat;
  rwp_pkg::fmt_info_t info;
  logic               sample_now;
  logic               div_done;
  logic               out_busy;

  // Status bundle for the controller.
  always_comb begin
    stat.sample_now = sample_now;
    stat.div_done   = div_done;
    stat.out_busy   = out_busy;
  end

  rwp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_byte (in_data.last_byte),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rwp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .din        (in_data),
    .sample_now (sample_now),
    .info       (info)
  );

  rwp_verdict u_verdict (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .data_byte  (in_data.data_byte),
    .sample_now (sample_now),
    .info       (info),
    .div_done   (div_done),
    .out_busy   (out_busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
